[rtl/core/fltpm_pkg.sv]
`timescale 1ns / 1ps

package fltpm_pkg;

    localparam int TABLE_FRAMES      = 64;
    localparam int ENTRIES_PER_TABLE = 512;

    localparam int IDX_W   = $clog2(ENTRIES_PER_TABLE);
    localparam int FRAME_W = $clog2(TABLE_FRAMES);
    localparam int NFREE_W = FRAME_W + 1;
    localparam int ADDR_W  = FRAME_W + IDX_W;
    localparam int DEPTH   = TABLE_FRAMES * ENTRIES_PER_TABLE;

    localparam int PTE_W   = 64;
    localparam int FRN_W   = 40;
    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int FLAGS_W = 12;

    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;

    localparam logic [FLAGS_W-1:0] PTE_PRESENT  = 12'h001;
    localparam logic [FLAGS_W-1:0] PTE_WRITABLE = 12'h002;
    localparam logic [FLAGS_W-1:0] PTE_USER     = 12'h004;
    localparam logic [FLAGS_W-1:0] PTE_GLOBAL   = 12'h100;

    localparam logic [FRN_W-1:0] BASE_RESET = 40'd256;

    localparam logic [1:0] KIND_MAP    = 2'd0;
    localparam logic [1:0] KIND_UNMAP  = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED  = 2'd2;

    // tag: entry written while its frame was allocated
    typedef struct packed {
        logic             tag;
        logic [PTE_W-1:0] pte;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic            inval;
        logic [PA_W-1:0] mapped;
        logic [1:0]      status;
    } t_result;

endpackage

[rtl/core/fltpm_ram.sv]
`timescale 1ns / 1ps

module fltpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/four_level_page_table_manager_top.sv]
`timescale 1ns / 1ps
// Four-level page table manager.
// Slave stream takes one request word: tuser = kind (0 map, 1 unmap, 2 lookup),
// tdata = virtual_address, physical_address, page_flags.
// Master stream returns one result word per request: status, mapped_address,
// invalidate. The cfg channel writes table_base_frame; ready is always high,
// write only while no request is in flight.
// Steps from accept to result: a map walks the three upper levels, writes the
// leaf in S_LEAF and hands its result over in S_DONE; unmap and lookup walk all
// four levels, a walk that stops early visits fewer, and an unused kind goes
// straight to S_DONE. Each table level is one read of the single table RAM
// (S_READ) followed by a check (S_CHECK); requests are handled one at a time.
// The next request is accepted while a result waits on a stalled receiver;
// that request then holds in S_DONE until the output register frees.
// Reset: a clearing pass writes all 32768 table entries, one per cycle, with
// tready low; cfg writes are still taken. Fresh frames read as zero through a
// per-entry tag, so allocation costs no clearing.

module four_level_page_table_manager_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [47:0] virtual_address, [99:48] physical_address, [111:100] page_flags
    input  logic [fltpm_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // [1:0] kind
    input  logic [fltpm_pkg::IN_USER_W-1:0]   i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [1:0] status, [53:2] mapped_address, [54] invalidate, [55] zero
    output logic [fltpm_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fltpm_pkg::FRN_W-1:0]       i_cfg_data
);

    import fltpm_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_CHECK = 6'b001000,
        S_LEAF  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [NFREE_W-1:0]  r_next_free, n_next_free;
    logic [FRN_W-1:0]    r_base;
    logic [1:0]          r_kind, n_kind;
    logic [VA_W-1:0]     r_va, n_va;
    logic [PA_W-1:0]     r_pa, n_pa;
    logic [FLAGS_W-1:0]  r_flags, n_flags;
    logic [1:0]          r_level, n_level;
    logic [FRAME_W-1:0]  r_cur, n_cur;
    t_result             r_res, n_res;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    t_entry              w_wdata;
    logic [ADDR_W-1:0]   w_raddr;
    t_entry              w_rdata;

    logic [IDX_W-1:0]    w_idx;
    logic                w_cur_alloc;
    logic [PTE_W-1:0]    w_pte;
    logic [FRN_W-1:0]    w_ent_frame;
    logic                w_ent_ok;
    logic [FRN_W-1:0]    w_new_phys;
    logic [FLAGS_W-1:0]  w_tflags;
    logic [FLAGS_W-1:0]  w_lflags;
    logic                w_accept;
    logic                w_out_free;
    logic                w_to_leaf;

    fltpm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {1'b0, r_out};

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        case (r_level)
            2'd3:    w_idx = r_va[47:39];
            2'd2:    w_idx = r_va[38:30];
            2'd1:    w_idx = r_va[29:21];
            default: w_idx = r_va[20:12];
        endcase
    end

    assign w_raddr     = {r_cur, w_idx};
    assign w_cur_alloc = ({1'b0, r_cur} < r_next_free);
    assign w_pte       = (w_rdata.tag == w_cur_alloc) ? w_rdata.pte : '0;
    assign w_ent_frame = w_pte[51:12] - r_base;
    assign w_ent_ok    = w_pte[0] && (w_ent_frame < FRN_W'(TABLE_FRAMES));
    assign w_new_phys  = r_base + FRN_W'(r_next_free);
    assign w_tflags    = PTE_PRESENT | PTE_WRITABLE | (r_flags & PTE_USER);
    assign w_lflags    = PTE_PRESENT | PTE_WRITABLE | (r_flags & ~PTE_USER)
                       | (r_flags[2] ? PTE_USER : PTE_GLOBAL);
    assign w_to_leaf   = (r_level == 2'd1) && (r_kind == KIND_MAP);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_next_free = r_next_free;
        n_kind      = r_kind;
        n_va        = r_va;
        n_pa        = r_pa;
        n_flags     = r_flags;
        n_level     = r_level;
        n_cur       = r_cur;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        w_we        = 1'b0;
        w_waddr     = w_raddr;
        w_wdata     = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_kind  = i_s_tuser;
                    n_va    = i_s_tdata[47:0];
                    n_pa    = i_s_tdata[99:48];
                    n_flags = i_s_tdata[111:100];
                    n_level = 2'd3;
                    n_cur   = '0;
                    n_res   = '0;
                    n_res.status = ST_DONE;
                    if (i_s_tuser == KIND_MAP || i_s_tuser == KIND_UNMAP ||
                        i_s_tuser == KIND_LOOKUP) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_level != 2'd0) begin
                    if (w_ent_ok) begin
                        n_cur   = w_ent_frame[FRAME_W-1:0];
                        n_level = r_level - 2'd1;
                        n_state = w_to_leaf ? S_LEAF : S_READ;
                    end else if (r_kind == KIND_MAP) begin
                        if (r_next_free >= NFREE_W'(TABLE_FRAMES)) begin
                            n_res.status = ST_EXHAUSTED;
                            n_state      = S_DONE;
                        end else begin
                            // a table pointing into the frame being allocated lands
                            // after that frame is cleared
                            w_we        = 1'b1;
                            w_wdata.tag = w_cur_alloc || ({1'b0, r_cur} == r_next_free);
                            w_wdata.pte = {12'b0, w_new_phys, w_tflags};
                            n_cur       = r_next_free[FRAME_W-1:0];
                            n_next_free = r_next_free + 1'b1;
                            n_level     = r_level - 2'd1;
                            n_state     = w_to_leaf ? S_LEAF : S_READ;
                        end
                    end else begin
                        n_res.status = ST_NOT_MAPPED;
                        n_state      = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                    if (r_kind == KIND_UNMAP) begin
                        w_we         = 1'b1;
                        w_wdata.tag  = w_cur_alloc;
                        n_res.inval  = 1'b1;
                        n_res.status = w_pte[0] ? ST_DONE : ST_NOT_MAPPED;
                    end else if (w_pte[0]) begin
                        n_res.status = ST_DONE;
                        n_res.mapped = {w_pte[51:12], 12'b0};
                    end else begin
                        n_res.status = ST_NOT_MAPPED;
                    end
                end
            end
            S_LEAF: begin
                w_we         = 1'b1;
                w_wdata.tag  = w_cur_alloc;
                w_wdata.pte  = {12'b0, r_pa[51:12], w_lflags};
                n_res.status = ST_DONE;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_next_free <= NFREE_W'(1);
            r_base      <= BASE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_va    <= n_va;
        r_pa    <= n_pa;
        r_flags <= n_flags;
        r_level <= n_level;
        r_cur   <= n_cur;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    a_nfree_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free != '0) && (r_next_free <= NFREE_W'(TABLE_FRAMES)))
        else $error("next free frame out of range");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE || r_state == S_READ) |-> !w_we)
        else $error("table write outside a write state");

    a_alloc_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && w_we && r_kind == KIND_MAP)
        |=> (r_next_free == $past(r_next_free) + 1'b1))
        else $error("table allocation did not advance the free frame");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_s_tready && w_we))
        else $error("request accepted during clearing pass");

endmodule

[test/four_level_page_table_manager_top_tb.sv]
`timescale 1ns / 1ps

module four_level_page_table_manager_top_tb;

    import fltpm_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 131072;  // covers the clearing pass after reset
    localparam int PHASE_ITEMS = 220;

    class page_table_mirror;
        bit [PTE_W-1:0]   entries [DEPTH];
        int unsigned      next_frame = 1;
        logic [FRN_W-1:0] base = BASE_RESET;
        t_result          pending_results[$];
        int unsigned      mismatches;
        int unsigned      n_kind[4];
        int unsigned      n_status[4];
        int unsigned      n_inval;
        int unsigned      n_base;

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void write_base(logic [FRN_W-1:0] v);
            base = v;
            n_base++;
        endfunction

        function int unsigned slot(int unsigned fr, logic [VA_W-1:0] va, int lvl);
            return fr * ENTRIES_PER_TABLE + int'(va[12 + IDX_W * lvl +: IDX_W]);
        endfunction

        // pointer outside the store, relative to the current base, counts as absent
        function bit table_frame(bit [PTE_W-1:0] e, output int unsigned fr);
            logic [FRN_W-1:0] rel;
            fr = 0;
            if ((e & PTE_PRESENT) == 0) return 1'b0;
            rel = e[51:12] - base;
            if (rel >= FRN_W'(TABLE_FRAMES)) return 1'b0;
            fr = int'(rel);
            return 1'b1;
        endfunction

        function bit find_pt(logic [VA_W-1:0] va, output int unsigned pt);
            int unsigned cur;
            int unsigned nxt;
            cur = 0;
            pt = 0;
            for (int lvl = 3; lvl >= 1; lvl--) begin
                if (!table_frame(entries[slot(cur, va, lvl)], nxt)) return 1'b0;
                cur = nxt;
            end
            pt = cur;
            return 1'b1;
        endfunction

        function logic [1:0] place_mapping(logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                                           logic [FLAGS_W-1:0] flags);
            bit [PTE_W-1:0]   tfl;
            bit [PTE_W-1:0]   lfl;
            int unsigned      cur;
            int unsigned      nxt;
            int unsigned      s;
            logic [FRN_W-1:0] fr;
            tfl = PTE_PRESENT | PTE_WRITABLE;
            lfl = tfl;
            if ((flags & PTE_USER) != 0) begin
                tfl |= PTE_USER;
                lfl |= PTE_USER;
            end else begin
                lfl |= PTE_GLOBAL;
            end
            lfl |= flags & ~PTE_USER;
            cur = 0;
            for (int lvl = 3; lvl >= 1; lvl--) begin
                s = slot(cur, va, lvl);
                if (!table_frame(entries[s], nxt)) begin
                    if (next_frame >= TABLE_FRAMES) return ST_EXHAUSTED;
                    nxt = next_frame;
                    next_frame++;
                    for (int i = 0; i < ENTRIES_PER_TABLE; i++)
                        entries[nxt * ENTRIES_PER_TABLE + i] = '0;
                    fr = base + nxt;
                    entries[s] = {12'h0, fr, 12'h0} | tfl;
                end
                cur = nxt;
            end
            entries[slot(cur, va, 0)] = {12'h0, pa[51:12], 12'h0} | lfl;
            return ST_DONE;
        endfunction

        function void note_request(logic [1:0] kind, logic [VA_W-1:0] va,
                                   logic [PA_W-1:0] pa, logic [FLAGS_W-1:0] flags);
            t_result     r;
            int unsigned pt;
            int unsigned s;
            r = '0;
            case (kind)
                KIND_MAP: begin
                    r.status = place_mapping(va, pa, flags);
                end
                KIND_UNMAP: begin
                    r.status = ST_NOT_MAPPED;
                    if (find_pt(va, pt)) begin
                        s = slot(pt, va, 0);
                        if ((entries[s] & PTE_PRESENT) != 0) r.status = ST_DONE;
                        entries[s] = '0;
                        r.inval = 1'b1;
                    end
                end
                KIND_LOOKUP: begin
                    r.status = ST_NOT_MAPPED;
                    if (find_pt(va, pt)) begin
                        s = slot(pt, va, 0);
                        if ((entries[s] & PTE_PRESENT) != 0) begin
                            r.status = ST_DONE;
                            r.mapped = {entries[s][51:12], 12'h0};
                        end
                    end
                end
                default: ;
            endcase
            n_kind[kind]++;
            n_status[r.status]++;
            n_inval += r.inval;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] word);
            t_result got;
            t_result want;
            got = word[$bits(t_result)-1:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h, no request outstanding", word);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.mapped !== want.mapped ||
                got.inval !== want.inval) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d addr %h inval %0d, got %0d %h %0d",
                             want.status, want.mapped, want.inval,
                             got.status, got.mapped, got.inval);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [IN_USER_W-1:0]  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [FRN_W-1:0]      i_cfg_data;

    page_table_mirror sb = new();
    int unsigned      quiet_cycles = 0;
    int unsigned      stall_left = 0;
    int unsigned      rx_cycle = 0;
    int unsigned      rx_mode = 0;

    logic [IDX_W-1:0] upper_pool [3] = '{9'd0, 9'd1, 9'd511};
    logic [IDX_W-1:0] leaf_pool  [8] = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd255, 9'd256,
                                         9'd510, 9'd511};

    four_level_page_table_manager_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: always ready, coin flip, or long stalls, mode picked at random
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
        if (stall_left != 0) begin
            i_m_tready = 1'b0;
            stall_left--;
        end else begin
            case (rx_mode)
                0: i_m_tready = 1'b1;
                1: i_m_tready = ($urandom_range(0, 1) == 1);
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(5, 20);
                        i_m_tready = 1'b0;
                    end else begin
                        i_m_tready = 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL four_level_page_table_manager_top");
            $finish;
        end
    end

    function automatic logic [63:0] rand_bits64();
        return {$urandom(), $urandom()};
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(logic [1:0] kind, logic [VA_W-1:0] va,
                                logic [PA_W-1:0] pa, logic [FLAGS_W-1:0] flags);
        i_s_tuser  = kind;
        i_s_tdata  = {flags, pa, va};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(kind, va, pa, flags);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_table_base(logic [FRN_W-1:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_base(v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // addresses mostly share a few table paths so tables get reused
    task automatic send_random();
        logic [63:0]      rnd;
        logic [VA_W-1:0]  va;
        logic [1:0]       kind;
        int unsigned      r;
        rnd = rand_bits64();
        va = rnd[VA_W-1:0];
        for (int lvl = 1; lvl <= 3; lvl++) begin
            if ($urandom_range(0, 99) < 94)
                va[12 + IDX_W * lvl +: IDX_W] = upper_pool[$urandom_range(0, 2)];
        end
        if ($urandom_range(0, 99) < 80) va[12 +: IDX_W] = leaf_pool[$urandom_range(0, 7)];
        r = $urandom_range(0, 99);
        if (r < 50)      kind = KIND_MAP;
        else if (r < 70) kind = KIND_UNMAP;
        else if (r < 95) kind = KIND_LOOKUP;
        else             kind = KIND_UNUSED;
        rnd = rand_bits64();
        send_request(kind, va, rnd[PA_W-1:0], rnd[63:52]);
    endtask

    initial begin
        logic [63:0]      rnd;
        logic [FRN_W-1:0] bases [5];
        int unsigned      burst_left;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        rnd = rand_bits64();
        send_request(KIND_LOOKUP, '0, '0, '0);
        send_request(KIND_UNMAP, '0, '0, '0);                     // upper table missing
        send_request(KIND_MAP, '0, '1, '0);                       // global leaf
        send_request(KIND_LOOKUP, '0, '0, '0);
        send_request(KIND_MAP, '1, '0, '1);                       // user leaf, all flags
        send_request(KIND_LOOKUP, '1, '0, '0);                    // present, frame zero
        send_request(KIND_MAP, 48'h0000_0000_5000, rnd[PA_W-1:0], PTE_USER);
        send_request(KIND_LOOKUP, 48'h0000_0000_5FFF, '0, '0);
        send_request(KIND_UNMAP, '1, '0, '0);
        send_request(KIND_UNMAP, '1, '0, '0);                     // leaf already clear
        send_request(KIND_LOOKUP, '1, '0, '0);
        send_request(KIND_UNUSED, rnd[VA_W-1:0], rnd[63:12], rnd[11:0]);
        send_request(KIND_MAP, '0, rnd[63:12], ~PTE_USER);        // overwrite leaf
        send_request(KIND_LOOKUP, '0, '0, '0);

        // base near the top: old pointers dangle, new frame addresses wrap
        settle();
        write_table_base(40'hFF_FFFF_FFFC);
        send_request(KIND_LOOKUP, '0, '0, '0);
        send_request(KIND_MAP, '0, rnd[PA_W-1:0], '0);            // replaces dangling tables
        send_request(KIND_LOOKUP, '0, '0, '0);
        send_request(KIND_UNMAP, '1, '0, '0);
        send_request(KIND_MAP, '1, '1, '0);
        send_request(KIND_LOOKUP, '1, '0, '0);

        rnd = rand_bits64();
        bases[0] = '0;
        bases[1] = '1;
        bases[2] = BASE_RESET;
        bases[3] = BASE_RESET + 1;   // old pointers alias onto neighbor frames
        bases[4] = rnd[FRN_W-1:0];

        for (int p = 0; p < 5; p++) begin
            settle();
            write_table_base(bases[p]);
            burst_left = 60;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2) settle();
                if (burst_left == 0) begin
                    i_s_tvalid = 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
                    burst_left = $urandom_range(1, 16);
                end
                send_random();
                burst_left--;
            end
        end

        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Ran %0d map, %0d unmap, %0d lookup, %0d unused-kind words over %0d bases",
                 sb.n_kind[KIND_MAP], sb.n_kind[KIND_UNMAP], sb.n_kind[KIND_LOOKUP],
                 sb.n_kind[KIND_UNUSED], sb.n_base + 1);
        $display("Results: %0d done, %0d not mapped, %0d out of frames, %0d invalidates",
                 sb.n_status[ST_DONE], sb.n_status[ST_NOT_MAPPED],
                 sb.n_status[ST_EXHAUSTED], sb.n_inval);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS four_level_page_table_manager_top");
        else
            $display("FAIL four_level_page_table_manager_top");
        $finish;
    end

endmodule
